[hw/rtl/mpse_pkg.sv]
// Shared constants, configuration types and helpers for the max pooling stream engine.
package mpse_pkg;

    localparam int MAX_CHANNELS     = 16;
    localparam int MAX_POOLED_WIDTH = 128;
    localparam int MAX_WINDOW       = 4;
    localparam int SAMPLE_BITS      = 16;

    localparam int ROW_BITS       = 12;
    localparam int COL_BITS       = 11;
    localparam int CNT_BITS       = 5;
    localparam int WIN_BITS       = 3;
    localparam int OFF_BITS       = 4;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 12;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_HEIGHT  = 3'd0,
        CFG_IMAGE_WIDTH   = 3'd1,
        CFG_CHANNEL_COUNT = 3'd2,
        CFG_WINDOW_SIZE   = 3'd3,
        CFG_WINDOW_STRIDE = 3'd4,
        CFG_FLOOR_AT_ZERO = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [ROW_BITS-1:0] height;
        logic [COL_BITS-1:0] width;
        logic [CNT_BITS-1:0] nch;
        logic [WIN_BITS-1:0] k;
        logic [WIN_BITS-1:0] s;
        logic                floor_zero;
    } t_cfg;

    function automatic int bits_for(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

[hw/rtl/mpse_queue.sv]
// Two-entry request queue between the front and back parts.
module mpse_queue
    import mpse_pkg::*;
#(
    parameter int DATA_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    input  logic                 i_pop,
    output logic [DATA_BITS-1:0] o_data,
    output logic                 o_full,
    output logic                 o_empty
);

    logic [DATA_BITS-1:0] r_mem [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

[hw/rtl/mpse_front.sv]
// Front part: accepts samples, tracks the raster position and queues valid requests.
module mpse_front
    import mpse_pkg::*;
#(
    parameter int MAX_CHANNELS = mpse_pkg::MAX_CHANNELS,
    parameter int SAMPLE_BITS  = mpse_pkg::SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_first_of_image,
    input  logic                   i_queue_full,
    output logic                   o_push,
    output logic [SAMPLE_BITS+ROW_BITS+COL_BITS+bits_for(MAX_CHANNELS)-1:0] o_data
);

    localparam int CW = bits_for(MAX_CHANNELS);

    logic [ROW_BITS-1:0] r_row;
    logic [COL_BITS-1:0] r_col;
    logic [CW-1:0]       r_chan;
    logic [ROW_BITS-1:0] cur_row;
    logic [COL_BITS-1:0] cur_col;
    logic [CW-1:0]       cur_chan;
    logic                accept;
    logic                chan_wrap;
    logic                col_wrap;
    logic                row_wrap;

    assign cur_row  = i_first_of_image ? '0 : r_row;
    assign cur_col  = i_first_of_image ? '0 : r_col;
    assign cur_chan = i_first_of_image ? '0 : r_chan;

    assign accept    = i_in_valid && !i_queue_full;
    assign o_in_stall = i_queue_full;

    assign chan_wrap = (8'(cur_chan) + 8'd1) >= 8'(i_cfg.nch);
    assign col_wrap  = ({1'b0, cur_col} + 12'd1) >= {1'b0, i_cfg.width};
    assign row_wrap  = ({1'b0, cur_row} + 13'd1) >= {1'b0, i_cfg.height};

    assign o_push = accept && (8'(cur_chan) < 8'(i_cfg.nch));
    assign o_data = {i_sample, cur_row, cur_col, cur_chan};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_chan <= '0;
        end else if (accept) begin
            if (chan_wrap) begin
                r_chan <= '0;
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= row_wrap ? '0 : cur_row + 1'b1;
                end else begin
                    r_col <= cur_col + 1'b1;
                    r_row <= cur_row;
                end
            end else begin
                r_chan <= cur_chan + 1'b1;
                r_col  <= cur_col;
                r_row  <= cur_row;
            end
        end
    end

endmodule

[hw/rtl/mpse_div.sv]
// Bit-serial divider that splits the row and column positions by the stride.
module mpse_div
    import mpse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [ROW_BITS-1:0] i_row,
    input  logic [COL_BITS-1:0] i_col,
    input  logic [WIN_BITS-1:0] i_div,
    output logic                o_done,
    output logic [ROW_BITS-1:0] o_row_quo,
    output logic [WIN_BITS-1:0] o_row_rem,
    output logic [COL_BITS-1:0] o_col_quo,
    output logic [WIN_BITS-1:0] o_col_rem
);

    logic                r_busy;
    logic                r_done;
    logic [3:0]          r_cnt;
    logic [ROW_BITS-1:0] r_rq;
    logic [ROW_BITS-1:0] r_cq;
    logic [WIN_BITS-1:0] r_rr;
    logic [WIN_BITS-1:0] r_cr;
    logic [WIN_BITS:0]   row_t;
    logic [WIN_BITS:0]   col_t;
    logic                row_ge;
    logic                col_ge;
    logic [WIN_BITS-1:0] n_rr;
    logic [WIN_BITS-1:0] n_cr;

    assign row_t  = {r_rr, r_rq[ROW_BITS-1]};
    assign col_t  = {r_cr, r_cq[ROW_BITS-1]};
    assign row_ge = row_t >= {1'b0, i_div};
    assign col_ge = col_t >= {1'b0, i_div};
    assign n_rr   = row_ge ? WIN_BITS'(row_t - {1'b0, i_div}) : row_t[WIN_BITS-1:0];
    assign n_cr   = col_ge ? WIN_BITS'(col_t - {1'b0, i_div}) : col_t[WIN_BITS-1:0];

    assign o_done    = r_done;
    assign o_row_quo = r_rq;
    assign o_row_rem = r_rr;
    assign o_col_quo = r_cq[COL_BITS-1:0];
    assign o_col_rem = r_cr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 4'(ROW_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rq <= i_row;
            r_cq <= {1'b0, i_col};
            r_rr <= '0;
            r_cr <= '0;
        end else if (r_busy) begin
            r_rq <= {r_rq[ROW_BITS-2:0], row_ge};
            r_cq <= {r_cq[ROW_BITS-2:0], col_ge};
            r_rr <= n_rr;
            r_cr <= n_cr;
        end
    end

endmodule

[hw/rtl/mpse_back.sv]
// Back part: walks the windows covering a sample and updates the partial-max memory.
module mpse_back
    import mpse_pkg::*;
#(
    parameter int MAX_CHANNELS     = mpse_pkg::MAX_CHANNELS,
    parameter int MAX_POOLED_WIDTH = mpse_pkg::MAX_POOLED_WIDTH,
    parameter int MAX_WINDOW       = mpse_pkg::MAX_WINDOW,
    parameter int SAMPLE_BITS      = mpse_pkg::SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_empty,
    input  logic [SAMPLE_BITS+ROW_BITS+COL_BITS+bits_for(MAX_CHANNELS)-1:0] i_data,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [SAMPLE_BITS-1:0] o_pooled_value,
    output logic [ROW_BITS-1:0]    o_pooled_row,
    output logic [bits_for(MAX_POOLED_WIDTH)-1:0] o_pooled_col,
    output logic [bits_for(MAX_CHANNELS)-1:0]     o_channel_index,
    output logic                   o_last_of_image
);

    localparam int CW    = bits_for(MAX_CHANNELS);
    localparam int PWB   = bits_for(MAX_POOLED_WIDTH);
    localparam int SLB   = bits_for(MAX_WINDOW);
    localparam int AW    = SLB + PWB + CW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_CHECK, S_RD, S_WR} t_state;

    t_state                  r_state;
    logic [SAMPLE_BITS-1:0]  mem [DEPTH];
    logic [SAMPLE_BITS-1:0]  r_rd;
    logic signed [SAMPLE_BITS-1:0] r_v;
    logic [ROW_BITS-1:0]     r_i;
    logic [COL_BITS-1:0]     r_j;
    logic [CW-1:0]           r_c;
    logic [ROW_BITS-1:0]     r_ph;
    logic [COL_BITS-1:0]     r_pw;
    logic [COL_BITS-1:0]     r_qc;
    logic [WIN_BITS-1:0]     r_rc;
    logic [OFF_BITS-1:0]     r_offr;
    logic [OFF_BITS-1:0]     r_offc;
    logic                    r_rowend;
    logic                    r_colend;
    logic                    r_o_valid;
    logic [SAMPLE_BITS-1:0]  r_o_value;
    logic [ROW_BITS-1:0]     r_o_row;
    logic [PWB-1:0]          r_o_col;
    logic [CW-1:0]           r_o_chan;
    logic                    r_o_last;

    logic                    div_done;
    logic [ROW_BITS-1:0]     row_quo;
    logic [WIN_BITS-1:0]     row_rem;
    logic [COL_BITS-1:0]     col_quo;
    logic [WIN_BITS-1:0]     col_rem;
    logic                    div_start;

    logic [OFF_BITS-1:0]     k4;
    logic [OFF_BITS-1:0]     s4;
    logic [ROW_BITS-1:0]     top_r;
    logic [COL_BITS-1:0]     top_c;
    logic                    row_ok;
    logic                    col_ok;
    logic [AW-1:0]           addr;
    logic                    is_start;
    logic                    is_end;
    logic                    out_free;
    logic                    go;
    logic signed [SAMPLE_BITS-1:0] old_v;
    logic [SAMPLE_BITS-1:0]  new_v;
    logic                    last_row;
    logic                    last_col;
    logic                    last_chan;

    mpse_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_row     (i_data[ROW_BITS+COL_BITS+CW-1 -: ROW_BITS]),
        .i_col     (i_data[COL_BITS+CW-1 -: COL_BITS]),
        .i_div     (i_cfg.s),
        .o_done    (div_done),
        .o_row_quo (row_quo),
        .o_row_rem (row_rem),
        .o_col_quo (col_quo),
        .o_col_rem (col_rem)
    );

    assign div_start = (r_state == S_IDLE) && !i_empty;
    assign o_pop     = div_start;

    assign k4    = OFF_BITS'(i_cfg.k);
    assign s4    = OFF_BITS'(i_cfg.s);
    assign top_r = r_i - ROW_BITS'(r_offr);
    assign top_c = r_j - COL_BITS'(r_offc);

    assign row_ok = ({1'b0, top_r} + 13'(i_cfg.k)) <= {1'b0, i_cfg.height};
    assign col_ok = (int'(r_pw) < MAX_POOLED_WIDTH)
                 && (({1'b0, top_c} + 12'(i_cfg.k)) <= {1'b0, i_cfg.width});

    assign addr = {r_ph[SLB-1:0], r_pw[PWB-1:0], r_c};

    assign is_start = (r_offr == '0) && (r_offc == '0);
    assign is_end   = (r_offr == k4 - 1'b1) && (r_offc == k4 - 1'b1);
    assign out_free = !r_o_valid || !i_out_stall;
    assign go       = (r_state == S_WR) && (!is_end || out_free);

    assign old_v = r_rd;
    always_comb begin
        if (is_start) begin
            new_v = (i_cfg.floor_zero && r_v < 0) ? '0 : r_v;
        end else begin
            new_v = (r_v > old_v) ? r_v : old_v;
        end
    end

    assign last_row  = ({1'b0, top_r} + 13'(i_cfg.s) + 13'(i_cfg.k)) > {1'b0, i_cfg.height};
    assign last_col  = (int'(r_pw) == MAX_POOLED_WIDTH - 1)
                    || (({1'b0, top_c} + 12'(i_cfg.s) + 12'(i_cfg.k)) > {1'b0, i_cfg.width});
    assign last_chan = (8'(r_c) + 8'd1) == 8'(i_cfg.nch);

    assign o_out_valid     = r_o_valid;
    assign o_pooled_value  = r_o_value;
    assign o_pooled_row    = r_o_row;
    assign o_pooled_col    = r_o_col;
    assign o_channel_index = r_o_chan;
    assign o_last_of_image = r_o_last;

    always_ff @(posedge i_clk) begin
        if (go) begin
            mem[addr] <= new_v;
        end
        if (r_state == S_RD) begin
            r_rd <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (go && is_end) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_v     <= i_data[SAMPLE_BITS+ROW_BITS+COL_BITS+CW-1 -: SAMPLE_BITS];
                        r_i     <= i_data[ROW_BITS+COL_BITS+CW-1 -: ROW_BITS];
                        r_j     <= i_data[COL_BITS+CW-1 -: COL_BITS];
                        r_c     <= i_data[CW-1:0];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_ph     <= row_quo;
                        r_offr   <= OFF_BITS'(row_rem);
                        r_pw     <= col_quo;
                        r_qc     <= col_quo;
                        r_offc   <= OFF_BITS'(col_rem);
                        r_rc     <= col_rem;
                        r_rowend <= 1'b0;
                        r_colend <= 1'b0;
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_offr >= k4 || r_rowend) begin
                        r_state <= S_IDLE;
                    end else if (r_offc >= k4 || r_colend) begin
                        r_offr <= r_offr + s4;
                        if (r_ph == '0) begin
                            r_rowend <= 1'b1;
                        end else begin
                            r_ph <= r_ph - 1'b1;
                        end
                        r_offc   <= OFF_BITS'(r_rc);
                        r_pw     <= r_qc;
                        r_colend <= 1'b0;
                    end else if (row_ok && col_ok) begin
                        r_state <= S_RD;
                    end else begin
                        r_offc <= r_offc + s4;
                        if (r_pw == '0) begin
                            r_colend <= 1'b1;
                        end else begin
                            r_pw <= r_pw - 1'b1;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (go) begin
                        if (is_end) begin
                            r_o_value <= new_v;
                            r_o_row   <= r_ph;
                            r_o_col   <= r_pw[PWB-1:0];
                            r_o_chan  <= r_c;
                            r_o_last  <= last_row && last_col && last_chan;
                        end
                        r_offc <= r_offc + s4;
                        if (r_pw == '0) begin
                            r_colend <= 1'b1;
                        end else begin
                            r_pw <= r_pw - 1'b1;
                        end
                        r_state <= S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/max_pool_stream_engine.sv]
// Top level of the streaming 2-D max pooling engine with its configuration registers.
// Each queued sample waits in the two-entry queue, then the back part runs the 12-step
// stride divider and a read and a write of the partial-max memory for each in-range window.
// The back part takes one sample at a time; while it is busy the queue holds up to two more.
// Reset: registers take their reset values, position, queue and output clear at once;
// the partial-max memory is not cleared and each entry is loaded at its window start.
module max_pool_stream_engine
    import mpse_pkg::*;
#(
    parameter int MAX_CHANNELS     = mpse_pkg::MAX_CHANNELS,
    parameter int MAX_POOLED_WIDTH = mpse_pkg::MAX_POOLED_WIDTH,
    parameter int MAX_WINDOW       = mpse_pkg::MAX_WINDOW,
    parameter int SAMPLE_BITS      = mpse_pkg::SAMPLE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [SAMPLE_BITS-1:0]    i_sample,
    input  logic                      i_first_of_image,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [SAMPLE_BITS-1:0]    o_pooled_value,
    output logic [ROW_BITS-1:0]       o_pooled_row,
    output logic [bits_for(MAX_POOLED_WIDTH)-1:0] o_pooled_col,
    output logic [bits_for(MAX_CHANNELS)-1:0]     o_channel_index,
    output logic                      o_last_of_image
);

    localparam int CW = bits_for(MAX_CHANNELS);
    localparam int QW = SAMPLE_BITS + ROW_BITS + COL_BITS + CW;

    logic [ROW_BITS-1:0] r_height;
    logic [COL_BITS-1:0] r_width;
    logic [CNT_BITS-1:0] r_chan_count;
    logic [WIN_BITS-1:0] r_win_size;
    logic [WIN_BITS-1:0] r_win_stride;
    logic                r_floor;
    t_cfg                cfg;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic [QW-1:0]       q_wdata;
    logic [QW-1:0]       q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height     <= ROW_BITS'(1);
            r_width      <= COL_BITS'(1);
            r_chan_count <= CNT_BITS'(1);
            r_win_size   <= WIN_BITS'(2);
            r_win_stride <= WIN_BITS'(2);
            r_floor      <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_HEIGHT:  r_height     <= i_cfg_data[ROW_BITS-1:0];
                CFG_IMAGE_WIDTH:   r_width      <= i_cfg_data[COL_BITS-1:0];
                CFG_CHANNEL_COUNT: r_chan_count <= i_cfg_data[CNT_BITS-1:0];
                CFG_WINDOW_SIZE:   r_win_size   <= i_cfg_data[WIN_BITS-1:0];
                CFG_WINDOW_STRIDE: r_win_stride <= i_cfg_data[WIN_BITS-1:0];
                CFG_FLOOR_AT_ZERO: r_floor      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.height     = r_height;
        cfg.width      = r_width;
        cfg.floor_zero = r_floor;
        if (r_chan_count == '0) begin
            cfg.nch = CNT_BITS'(1);
        end else if (int'(r_chan_count) > MAX_CHANNELS) begin
            cfg.nch = CNT_BITS'(MAX_CHANNELS);
        end else begin
            cfg.nch = r_chan_count;
        end
        if (r_win_size == '0) begin
            cfg.k = WIN_BITS'(1);
        end else if (int'(r_win_size) > MAX_WINDOW) begin
            cfg.k = WIN_BITS'(MAX_WINDOW);
        end else begin
            cfg.k = r_win_size;
        end
        cfg.s = (r_win_stride == '0) ? WIN_BITS'(1) : r_win_stride;
    end

    mpse_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample         (i_sample),
        .i_first_of_image (i_first_of_image),
        .i_queue_full     (q_full),
        .o_push           (q_push),
        .o_data           (q_wdata)
    );

    mpse_queue #(
        .DATA_BITS (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mpse_back #(
        .MAX_CHANNELS     (MAX_CHANNELS),
        .MAX_POOLED_WIDTH (MAX_POOLED_WIDTH),
        .MAX_WINDOW       (MAX_WINDOW),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_empty         (q_empty),
        .i_data          (q_rdata),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pooled_value  (o_pooled_value),
        .o_pooled_row    (o_pooled_row),
        .o_pooled_col    (o_pooled_col),
        .o_channel_index (o_channel_index),
        .o_last_of_image (o_last_of_image)
    );

endmodule

[tb/sv/max_pool_stream_engine_checker.sv]
// Checker for the max pooling stream engine: predicts window maxima and compares the results.
module max_pool_stream_engine_checker
    import mpse_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [SAMPLE_BITS-1:0]    i_sample,
    input  logic                      i_first_of_image,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [SAMPLE_BITS-1:0]    i_pooled_value,
    input  logic [ROW_BITS-1:0]       i_pooled_row,
    input  logic [6:0]                i_pooled_col,
    input  logic [3:0]                i_channel_index,
    input  logic                      i_last_of_image,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_results
);

    typedef struct packed {
        logic signed [15:0] value;
        logic [11:0]        row;
        logic [6:0]         col;
        logic [3:0]         chan;
        logic               last;
    } t_pooled;

    localparam int STORE_DEPTH = MAX_WINDOW * MAX_POOLED_WIDTH * MAX_CHANNELS;

    logic signed [15:0] partial_max [0:STORE_DEPTH-1];
    t_pooled            window_max_q[$];

    logic [11:0] cfg_height;
    logic [10:0] cfg_width;
    logic [4:0]  cfg_nch;
    logic [2:0]  cfg_k;
    logic [2:0]  cfg_s;
    logic        cfg_floor;
    int          row_pos;
    int          col_pos;
    int          chan_pos;

    task automatic report_mismatch(input string msg);
        $display("ERROR %s", msg);
        o_errors++;
    endtask

    function automatic int pooled_extent(input int extent, input int k, input int s);
        if (extent < k) begin
            return 0;
        end
        return (extent - k) / s + 1;
    endfunction

    task automatic pool_sample(input logic signed [15:0] v, input logic first);
        int      nch, k, s, phn, pwn, hs, he, ws, we_end, ph, pw, idx;
        t_pooled r;
        if (first) begin
            row_pos  = 0;
            col_pos  = 0;
            chan_pos = 0;
        end
        nch = (cfg_nch < 1) ? 1 : ((cfg_nch > MAX_CHANNELS) ? MAX_CHANNELS : int'(cfg_nch));
        k   = (cfg_k < 1) ? 1 : ((cfg_k > MAX_WINDOW) ? MAX_WINDOW : int'(cfg_k));
        s   = (cfg_s < 1) ? 1 : int'(cfg_s);
        phn = pooled_extent(cfg_height, k, s);
        pwn = pooled_extent(cfg_width, k, s);
        if (pwn > MAX_POOLED_WIDTH) begin
            pwn = MAX_POOLED_WIDTH;
        end
        if (chan_pos < nch) begin
            hs     = (row_pos < k) ? 0 : (row_pos - k) / s + 1;
            he     = row_pos / s + 1;
            he     = (he > phn) ? phn : he;
            ws     = (col_pos < k) ? 0 : (col_pos - k) / s + 1;
            we_end = col_pos / s + 1;
            we_end = (we_end > pwn) ? pwn : we_end;
            for (ph = hs; ph < he; ph++) begin
                for (pw = ws; pw < we_end; pw++) begin
                    idx = (((ph % MAX_WINDOW) * MAX_POOLED_WIDTH + pw) * MAX_CHANNELS)
                          + chan_pos;
                    if (row_pos == ph * s && col_pos == pw * s) begin
                        partial_max[idx] = (cfg_floor && v < 0) ? 16'sd0 : v;
                    end else if (v > partial_max[idx]) begin
                        partial_max[idx] = v;
                    end
                    if (row_pos == ph * s + k - 1 && col_pos == pw * s + k - 1) begin
                        r.value = partial_max[idx];
                        r.row   = ph[11:0];
                        r.col   = pw[6:0];
                        r.chan  = chan_pos[3:0];
                        r.last  = (ph + 1 == phn) && (pw + 1 == pwn) && (chan_pos + 1 == nch);
                        window_max_q.push_back(r);
                    end
                end
            end
        end
        if (chan_pos + 1 >= nch) begin
            chan_pos = 0;
            if (col_pos + 1 >= cfg_width) begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= cfg_height) ? 0 : (row_pos + 1) & 12'hFFF;
            end else begin
                col_pos = (col_pos + 1) & 11'h7FF;
            end
        end else begin
            chan_pos = (chan_pos + 1) & 4'hF;
        end
    endtask

    task automatic check_result();
        t_pooled e;
        o_results++;
        if (window_max_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d row %0d col %0d",
                            $signed(i_pooled_value), i_pooled_row, i_pooled_col));
            return;
        end
        e = window_max_q.pop_front();
        if ($signed(i_pooled_value) != e.value || i_pooled_row != e.row
                || i_pooled_col != e.col || i_channel_index != e.chan
                || i_last_of_image != e.last) begin
            report_mismatch($sformatf(
                "got val %0d row %0d col %0d ch %0d last %0b, want %0d %0d %0d %0d %0b",
                $signed(i_pooled_value), i_pooled_row, i_pooled_col, i_channel_index,
                i_last_of_image, e.value, e.row, e.col, e.chan, e.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_height = 12'd1;
            cfg_width  = 11'd1;
            cfg_nch    = 5'd1;
            cfg_k      = 3'd2;
            cfg_s      = 3'd2;
            cfg_floor  = 1'b1;
            row_pos    = 0;
            col_pos    = 0;
            chan_pos   = 0;
            window_max_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_IMAGE_HEIGHT:  cfg_height = i_cfg_data[11:0];
                    CFG_IMAGE_WIDTH:   cfg_width  = i_cfg_data[10:0];
                    CFG_CHANNEL_COUNT: cfg_nch    = i_cfg_data[4:0];
                    CFG_WINDOW_SIZE:   cfg_k      = i_cfg_data[2:0];
                    CFG_WINDOW_STRIDE: cfg_s      = i_cfg_data[2:0];
                    CFG_FLOOR_AT_ZERO: cfg_floor  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                pool_sample($signed(i_sample), i_first_of_image);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
        end
        o_pending = window_max_q.size();
    end

endmodule

[tb/sv/max_pool_stream_engine_tb.sv]
// Testbench top for the max pooling stream engine: stimulus, handshakes and verdict.
module max_pool_stream_engine_tb;
    import mpse_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 400;
    localparam int ITEMS       = 1600;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [SAMPLE_BITS-1:0]    i_sample;
    logic                      i_first_of_image;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [SAMPLE_BITS-1:0]    o_pooled_value;
    logic [ROW_BITS-1:0]       o_pooled_row;
    logic [6:0]                o_pooled_col;
    logic [3:0]                o_channel_index;
    logic                      o_last_of_image;

    int errors, pending, results;
    int samples_sent = 0;
    int phases = 0;
    int cycles = 0;
    bit quiet = 0;
    bit hold_req = 0;

    max_pool_stream_engine dut (.*);

    max_pool_stream_engine_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_sample, .i_first_of_image,
        .i_out_valid(o_out_valid), .i_out_stall,
        .i_pooled_value(o_pooled_value), .i_pooled_row(o_pooled_row),
        .i_pooled_col(o_pooled_col), .i_channel_index(o_channel_index),
        .i_last_of_image(o_last_of_image),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending.", cycles, pending);
            $display("max_pool_stream_engine: mismatch");
            $finish;
        end
    end

    initial begin
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input t_cfg_index idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_BITS-1:0];
        @(posedge i_clk);
    endtask

    // Waits for the engine to drain before the registers change.
    task automatic configure(input int h, input int w, input int nch, input int k,
                             input int s, input int floor_zero);
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(posedge i_clk);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_CHANNEL_COUNT, nch);
        write_reg(CFG_WINDOW_SIZE, k);
        write_reg(CFG_WINDOW_STRIDE, s);
        write_reg(CFG_FLOOR_AT_ZERO, floor_zero);
        i_cfg_we <= 1'b0;
        phases++;
    endtask

    task automatic send_sample(input logic [15:0] value, input logic first);
        i_in_valid       <= 1'b1;
        i_sample         <= value;
        i_first_of_image <= first;
        do @(posedge i_clk); while (o_in_stall);
        samples_sent++;
        if (samples_sent > ITEMS - 200) begin
            quiet = 1;
        end
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_image(input int count);
        for (int n = 0; n < count && samples_sent < ITEMS; n++) begin
            send_sample(random_sample(), n == 0);
        end
    endtask

    initial begin
        int h, w, nch, eff, count;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_sample         = '0;
        i_first_of_image = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A one-pixel image under the reset window never completes a window.
        send_sample(16'h0005, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);

        configure(2, 2, 1, 2, 2, 1);
        send_sample(16'hFFFB, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFF9, 1'b0);

        configure(2, 2, 1, 2, 2, 0);
        send_sample(16'hFFFB, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h7FFF, 1'b0);

        configure(3, 3, 2, 2, 1, 0);
        hold_req = 1;
        send_image(18);

        configure(4095, 1024, 0, 0, 0, 1);
        send_image(8);

        while (samples_sent < ITEMS) begin
            if (phases % 17 == 5) begin
                configure(1, $urandom_range(129, 300), 1, $urandom_range(1, 2), 1,
                          $urandom_range(0, 1));
                count = 300;
            end else if (phases % 23 == 9) begin
                configure(4095, 2047, 31, 7, 7, $urandom_range(0, 1));
                count = 20;
            end else begin
                nch = $urandom_range(0, 31);
                eff = (nch == 0) ? 1 : ((nch > 16) ? 16 : nch);
                h   = $urandom_range(0, 7);
                w   = $urandom_range(0, 7);
                configure(h, w, nch, $urandom_range(0, 7), $urandom_range(0, 7),
                          $urandom_range(0, 1));
                count = ((h == 0) ? 1 : h) * ((w == 0) ? 1 : w) * eff;
                if (count > 200) begin
                    count = 200;
                end
            end
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_image($urandom_range(1, count));
                end else begin
                    send_image(count);
                end
            end
        end

        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(posedge i_clk);
        $display("Sent %0d samples over %0d register settings and checked %0d results.",
                 samples_sent, phases, results);
        $display("Covered overlapping and wide windows, clamping, and degenerate registers.");
        if (errors == 0) begin
            $display("max_pool_stream_engine: match");
        end else begin
            $display("max_pool_stream_engine: mismatch");
        end
        $finish;
    end

endmodule

[max_pool_stream_engine.f]
hw/rtl/mpse_pkg.sv
hw/rtl/mpse_queue.sv
hw/rtl/mpse_front.sv
hw/rtl/mpse_div.sv
hw/rtl/mpse_back.sv
hw/rtl/max_pool_stream_engine.sv
tb/sv/max_pool_stream_engine_checker.sv
tb/sv/max_pool_stream_engine_tb.sv
